@@ rtl/bat_pkg.sv @@
package bat_pkg;

  // table geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // command codes
  localparam logic [2:0] CMD_ALLOC      = 3'd0;
  localparam logic [2:0] CMD_MARK_END   = 3'd1;
  localparam logic [2:0] CMD_READ_LINK  = 3'd2;
  localparam logic [2:0] CMD_FREE_BLOCK = 3'd3;
  localparam logic [2:0] CMD_FREE_CHAIN = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_BAD_IDX = 2'd2;

  // entry kinds
  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;
  localparam logic [1:0] KIND_LINK  = 2'd3;

  // configuration register indexes
  localparam logic CFG_BLOCKS_IN_USE = 1'b0;
  localparam logic CFG_BLOCK_BYTES   = 1'b1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] block_index;
    logic       link_previous;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  result_block;
    logic [13:0] byte_address;
    logic [1:0]  entry_kind;
    logic [5:0]  link_target;
    logic [6:0]  freed_count;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_LINK_WR,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_CHAIN_RD,
    ST_CHAIN_CHK,
    ST_RPT_RD,
    ST_RPT,
    ST_RPT_NONE
  } state_t;

  typedef enum logic [1:0] {
    BLK_ZERO,
    BLK_IDX,
    BLK_PTR
  } blk_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       rd_sel_idx;
    logic       wr_en;
    logic       wr_sel_idx;
    logic [1:0] wr_kind;
    logic       ptr_inc;
    logic       ptr_from_idx;
    logic       ptr_from_link;
    logic       cnt_inc;
    logic       out_load;
    logic [1:0] out_status;
    blk_sel_t   out_blk_sel;
    logic       out_show;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       link_prev;
    logic       idx_oor;
    logic       ptr_end;
    logic       cnt_end;
    logic [1:0] rd_kind;
    logic       link_oor;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ rtl/bat_dp.sv @@
module bat_dp import bat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_ctl_t    ctl,
  output dp_sts_t    sts,
  input  in_word_t   in_data,
  input  logic [6:0] blocks_in_use,
  input  logic [7:0] block_bytes,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  // table store: kind in the top two bits, link below
  logic [7:0]            mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_r;

  logic [2:0]       cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic             link_r;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       rd_q_r;
  logic             rd_vld_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r;

  logic [CNT_W-1:0] n_w;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [1:0]       rd_kind;
  logic [IDX_W-1:0] rd_link;
  logic [IDX_W-1:0] blk;
  logic [13:0]      prod;

  // usable entry count
  assign n_w = (blocks_in_use > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : blocks_in_use;

  assign rd_addr = ctl.rd_sel_idx ? idx_r : ptr_r[IDX_W-1:0];
  assign wr_addr = ctl.wr_sel_idx ? idx_r : ptr_r[IDX_W-1:0];
  assign rd_kind = rd_vld_r ? rd_q_r[7:6] : KIND_FREE;
  assign rd_link = rd_q_r[IDX_W-1:0];

  // item capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_data.cmd;
      idx_r  <= in_data.block_index;
      link_r <= in_data.link_previous;
    end
  end

  // walk pointer and freed counter
  always_comb begin
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      ptr_nxt = '0;
      cnt_nxt = '0;
    end else begin
      if (ctl.ptr_from_idx) begin
        ptr_nxt = {1'b0, idx_r};
      end else if (ctl.ptr_from_link) begin
        ptr_nxt = {1'b0, rd_link};
      end else if (ctl.ptr_inc) begin
        ptr_nxt = ptr_r + 1'b1;
      end
      if (ctl.cnt_inc) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {ctl.wr_kind, ptr_r[IDX_W-1:0]};
    end
    if (ctl.rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // written flags, an unwritten entry reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // result word
  always_comb begin
    unique case (ctl.out_blk_sel)
      BLK_IDX: blk = idx_r;
      BLK_PTR: blk = ptr_r[IDX_W-1:0];
      default: blk = '0;
    endcase
  end

  assign prod = {8'b0, blk} * {6'b0, block_bytes};

  assign out_valid_nxt = ctl.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.status       <= ctl.out_status;
      out_data_r.result_block <= blk;
      out_data_r.byte_address <= prod;
      out_data_r.entry_kind   <= ctl.out_show ? rd_kind : KIND_FREE;
      out_data_r.link_target  <= (ctl.out_show && rd_kind == KIND_LINK) ? rd_link : '0;
      out_data_r.freed_count  <= ctl.out_show ? cnt_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to controller
  assign sts.cmd       = cmd_r;
  assign sts.link_prev = link_r;
  assign sts.idx_oor   = {1'b0, idx_r} >= n_w;
  assign sts.ptr_end   = ptr_r >= n_w;
  assign sts.cnt_end   = cnt_r >= n_w;
  assign sts.rd_kind   = rd_kind;
  assign sts.link_oor  = {1'b0, rd_link} >= n_w;
  assign sts.out_free  = !out_valid_r || !out_stall;

`ifndef NO_ASSERTIONS
  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.rd_en && ctl.wr_en))
    else $error("table read and write in one cycle");

  a_alloc_free_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_en && ctl.wr_kind == KIND_ALLOC) |-> (rd_kind == KIND_FREE))
    else $error("allocation of an entry that is not free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");
`endif

endmodule

@@ rtl/bat_ctrl.sv @@
module bat_ctrl import bat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_ctl_t ctl,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   names_idx;

  assign names_idx = (sts.cmd != CMD_ALLOC) || sts.link_prev;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    ctl.out_blk_sel = BLK_ZERO;
    ctl.out_status  = STS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.cmd > CMD_FREE_CHAIN || (names_idx && sts.idx_oor)) begin
          state_nxt = ST_RPT_NONE;
        end else begin
          unique case (sts.cmd)
            CMD_ALLOC: state_nxt = ST_SCAN_RD;
            CMD_MARK_END: begin
              ctl.wr_en      = 1'b1;
              ctl.wr_sel_idx = 1'b1;
              ctl.wr_kind    = KIND_END;
              state_nxt      = ST_RPT_RD;
            end
            CMD_READ_LINK:  state_nxt = ST_RPT_RD;
            CMD_FREE_BLOCK: state_nxt = ST_FREE_RD;
            default: begin
              ctl.ptr_from_idx = 1'b1;
              state_nxt        = ST_CHAIN_RD;
            end
          endcase
        end
      end
      // lowest free entry search
      ST_SCAN_RD: begin
        if (sts.ptr_end) begin
          state_nxt = ST_RPT_NONE;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.rd_kind == KIND_FREE) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_kind = KIND_ALLOC;
          state_nxt   = sts.link_prev ? ST_LINK_WR : ST_RPT_RD;
        end else begin
          ctl.ptr_inc = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_LINK_WR: begin
        ctl.wr_en      = 1'b1;
        ctl.wr_sel_idx = 1'b1;
        ctl.wr_kind    = KIND_LINK;
        state_nxt      = ST_RPT_RD;
      end
      // single block free
      ST_FREE_RD: begin
        ctl.rd_en      = 1'b1;
        ctl.rd_sel_idx = 1'b1;
        state_nxt      = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        ctl.cnt_inc    = (sts.rd_kind != KIND_FREE);
        ctl.wr_en      = 1'b1;
        ctl.wr_sel_idx = 1'b1;
        ctl.wr_kind    = KIND_FREE;
        state_nxt      = ST_RPT_RD;
      end
      // chain walk, bounded by the usable count
      ST_CHAIN_RD: begin
        if (sts.cnt_end) begin
          state_nxt = ST_RPT_RD;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_CHAIN_CHK;
        end
      end
      ST_CHAIN_CHK: begin
        if (sts.rd_kind == KIND_FREE) begin
          state_nxt = ST_RPT_RD;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_kind = KIND_FREE;
          ctl.cnt_inc = 1'b1;
          if (sts.rd_kind != KIND_LINK || sts.link_oor) begin
            state_nxt = ST_RPT_RD;
          end else begin
            ctl.ptr_from_link = 1'b1;
            state_nxt         = ST_CHAIN_RD;
          end
        end
      end
      // fetch the reported entry
      ST_RPT_RD: begin
        ctl.rd_en      = 1'b1;
        ctl.rd_sel_idx = (sts.cmd != CMD_ALLOC);
        state_nxt      = ST_RPT;
      end
      ST_RPT: begin
        ctl.out_blk_sel = (sts.cmd == CMD_ALLOC) ? BLK_PTR : BLK_IDX;
        ctl.out_show    = 1'b1;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      // unknown command, bad index or full table
      ST_RPT_NONE: begin
        if (sts.cmd > CMD_FREE_CHAIN) begin
          ctl.out_status = STS_OK;
        end else if (names_idx && sts.idx_oor) begin
          ctl.out_status  = STS_BAD_IDX;
          ctl.out_blk_sel = BLK_IDX;
        end else begin
          ctl.out_status = STS_FULL;
        end
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> state_r == ST_IDLE)
    else $error("item taken while busy");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("result written over a waiting word");

  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CHK || state_r == ST_CHAIN_CHK) |-> $past(ctl.rd_en))
    else $error("entry checked without a read");
`endif

endmodule

@@ rtl/block_allocation_table_top.sv @@
// steps from accept to result taken: bad index or unknown command, decode and no-result
// report; mark end and read link, decode, report read and report; free block adds an
// entry read and write; allocate reads and checks each entry scanned, writes the link
// when linking; free chain reads and checks each entry visited, plus a read state when
// the usable count ends the walk; one word at a time, the single port table serialises
// each walk; next word accepted in idle; reset: synchronous, table all free
module block_allocation_table_top import bat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [6:0] blocks_in_use_r;
  logic [7:0] block_bytes_r;
  dp_ctl_t    ctl;
  dp_sts_t    sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= 7'd40;
      block_bytes_r   <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata[6:0];
        CFG_BLOCK_BYTES:   block_bytes_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  bat_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_data       (in_data),
    .blocks_in_use (blocks_in_use_r),
    .block_bytes   (block_bytes_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

@@ tb/block_allocation_table_top_tb.sv @@
`timescale 1ns / 1ps

module block_allocation_table_top_tb;
  import bat_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [7:0] cfg_wdata;

  // shadow copy of the allocation table and its registers
  logic [1:0] fat_kind [MAX_BLOCKS];
  logic [5:0] fat_next [MAX_BLOCKS];
  logic [6:0] blocks_in_use_m;
  logic [7:0] block_bytes_m;

  out_word_t pending_results[$];
  out_word_t last_pred;
  int        fail_cnt;
  int        rx_hold;
  logic      idle_on;

  block_allocation_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned usable_blocks();
    return (blocks_in_use_m < MAX_BLOCKS) ? blocks_in_use_m : MAX_BLOCKS;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  function automatic in_word_t mk_word(logic [2:0] c, logic [5:0] b, logic l);
    in_word_t w;
    w.cmd           = c;
    w.block_index   = b;
    w.link_previous = l;
    return w;
  endfunction

  // applies one command to the shadow table and returns the word it should produce
  function automatic out_word_t apply_table_cmd(in_word_t w);
    out_word_t   r;
    int unsigned n, i, freed;
    logic [5:0]  blk, cur, nx;
    logic [1:0]  k;
    logic        done;
    r     = '0;
    n     = usable_blocks();
    freed = 0;
    blk   = w.block_index;
    // unknown codes leave the table alone and report zeros
    if (w.cmd > CMD_FREE_CHAIN) return r;
    // index check, allocate only when it names a previous block
    if ((w.cmd != CMD_ALLOC || w.link_previous) && w.block_index >= n) begin
      r.status       = STS_BAD_IDX;
      r.result_block = w.block_index;
      r.byte_address = 14'(32'(w.block_index) * 32'(block_bytes_m));
      return r;
    end
    case (w.cmd)
      CMD_ALLOC: begin
        i = 0;
        while (i < n && fat_kind[i] != KIND_FREE) i++;
        if (i >= n) begin
          r.status = STS_FULL;
          return r;
        end
        fat_kind[i] = KIND_ALLOC;
        // previous block may be the new block itself, giving a self link
        if (w.link_previous) begin
          fat_kind[w.block_index] = KIND_LINK;
          fat_next[w.block_index] = 6'(i);
        end
        blk = 6'(i);
      end
      CMD_MARK_END: fat_kind[blk] = KIND_END;
      CMD_READ_LINK: ;
      CMD_FREE_BLOCK: begin
        if (fat_kind[blk] != KIND_FREE) freed = 1;
        fat_kind[blk] = KIND_FREE;
      end
      default: begin
        // chain walk, bounded by the usable count so loops end
        cur  = blk;
        done = 1'b0;
        i    = 0;
        while (!done && i < n) begin
          k  = fat_kind[cur];
          nx = fat_next[cur];
          if (k == KIND_FREE) begin
            done = 1'b1;
          end else begin
            fat_kind[cur] = KIND_FREE;
            freed++;
            if (k != KIND_LINK || nx >= n) done = 1'b1;
            else cur = nx;
          end
          i++;
        end
      end
    endcase
    r.status       = STS_OK;
    r.result_block = blk;
    r.byte_address = 14'(32'(blk) * 32'(block_bytes_m));
    r.entry_kind   = fat_kind[blk];
    r.link_target  = (fat_kind[blk] == KIND_LINK) ? fat_next[blk] : 6'd0;
    r.freed_count  = 7'(freed);
    return r;
  endfunction

  // offer one word, optionally after a gap, and predict it once taken
  task automatic send_cmd(in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap_len() - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    last_pred = apply_table_cmd(w);
    pending_results.push_back(last_pred);
  endtask

  // sender pauses until every expected word is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_BLOCKS_IN_USE) blocks_in_use_m = val[6:0];
    else block_bytes_m = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // allocate a chain 0 -> 1 -> ... of the given length
  task automatic fill_chain(int cnt);
    int i;
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    for (i = 1; i < cnt; i++) send_cmd(mk_word(CMD_ALLOC, 6'(i - 1), 1'b1));
  endtask

  // short directed sequence at the reset settings
  task automatic test_directed_cmds();
    logic [3:0] c;
    send_cmd(mk_word(CMD_READ_LINK, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd63, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b1));
    send_cmd(mk_word(CMD_ALLOC, 6'd1, 1'b1));
    send_cmd(mk_word(CMD_MARK_END, 6'd2, 1'b0));
    send_cmd(mk_word(CMD_READ_LINK, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_FREE_BLOCK, 6'd5, 1'b0));
    // lowest free block named as its own previous block
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b1));
    send_cmd(mk_word(CMD_READ_LINK, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd1, 1'b1));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd1, 1'b0));
    // indexes beyond the blocks in use, and the last block in use
    send_cmd(mk_word(CMD_FREE_BLOCK, 6'd63, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd40, 1'b1));
    send_cmd(mk_word(CMD_MARK_END, 6'd45, 1'b0));
    send_cmd(mk_word(CMD_MARK_END, 6'd39, 1'b0));
    send_cmd(mk_word(CMD_FREE_BLOCK, 6'd39, 1'b0));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd39, 1'b0));
    send_cmd(mk_word(CMD_READ_LINK, 6'd39, 1'b0));
    // unused command codes
    for (c = 4'(CMD_FREE_CHAIN) + 4'd1; c < 4'd8; c++) send_cmd(mk_word(c[2:0], 6'd63, 1'b1));
  endtask

  // register extremes: one block, full table, zero and oversized counts
  task automatic test_register_extremes();
    drain_results();
    write_reg(CFG_BLOCK_BYTES, 8'd255);
    write_reg(CFG_BLOCKS_IN_USE, 8'd1);
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd1, 1'b1));
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b1));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd64);
    fill_chain(MAX_BLOCKS);
    send_cmd(mk_word(CMD_ALLOC, 6'd10, 1'b1));
    send_cmd(mk_word(CMD_READ_LINK, 6'd63, 1'b0));
    // lowering the count keeps upper entries and cuts the walk short
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd8);
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd64);
    send_cmd(mk_word(CMD_READ_LINK, 6'd20, 1'b0));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd8, 1'b0));
    fill_chain(MAX_BLOCKS);
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd0);
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_READ_LINK, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd127);
    send_cmd(mk_word(CMD_READ_LINK, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_MARK_END, 6'd63, 1'b0));
    send_cmd(mk_word(CMD_FREE_BLOCK, 6'd63, 1'b0));
  endtask

  // random phases: mostly chain building and freeing, some noise
  task automatic test_random_chains();
    int unsigned n, sel, ph, k;
    logic [5:0]  head, tail, pick;
    logic        tail_ok;
    in_word_t    w;
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(CFG_BLOCKS_IN_USE, 8'd64);
          write_reg(CFG_BLOCK_BYTES, 8'd255);
        end
        1: begin
          write_reg(CFG_BLOCKS_IN_USE, 8'd1);
          write_reg(CFG_BLOCK_BYTES, 8'd1);
        end
        default: begin
          write_reg(CFG_BLOCKS_IN_USE, 8'($urandom_range(2, (ph % 2 == 1) ? 64 : 12)));
          write_reg(CFG_BLOCK_BYTES, 8'($urandom_range(1, 255)));
        end
      endcase
      idle_on = (ph % 3 != 2);
      n       = usable_blocks();
      head    = '0;
      tail    = '0;
      tail_ok = 1'b0;
      for (k = 0; k < 160; k++) begin
        sel  = $urandom_range(0, 99);
        pick = (n == 0) ? 6'd0 : 6'($urandom_range(0, n - 1));
        if (sel < 45) begin
          if (tail_ok && $urandom_range(0, 3) != 0) w = mk_word(CMD_ALLOC, tail, 1'b1);
          else w = mk_word(CMD_ALLOC, 6'($urandom_range(0, 63)), 1'b0);
        end else if (sel < 53) begin
          w = mk_word(CMD_MARK_END, tail, 1'b0);
        end else if (sel < 63) begin
          w = mk_word(CMD_READ_LINK, pick, 1'($urandom_range(0, 1)));
        end else if (sel < 71) begin
          w = mk_word(CMD_FREE_BLOCK, pick, 1'($urandom_range(0, 1)));
        end else if (sel < 88) begin
          w = mk_word(CMD_FREE_CHAIN, ($urandom_range(0, 3) != 0) ? head : pick, 1'b0);
        end else begin
          w = in_word_t'(10'($urandom_range(0, 1023)));
        end
        send_cmd(w);
        // follow the chain being built
        if (w.cmd == CMD_ALLOC && last_pred.status == STS_OK) begin
          if (!w.link_previous) head = last_pred.result_block;
          tail    = last_pred.result_block;
          tail_ok = 1'b1;
        end else if (w.cmd == CMD_FREE_CHAIN && w.block_index == head) begin
          tail_ok = 1'b0;
        end
      end
    end
  endtask

  // receiver holds off long enough for the input to back up
  task automatic test_backpressure();
    int i;
    drain_results();
    write_reg(CFG_BLOCKS_IN_USE, 8'd16);
    write_reg(CFG_BLOCK_BYTES, 8'd3);
    idle_on = 1'b0;
    rx_hold = 400;
    send_cmd(mk_word(CMD_ALLOC, 6'd0, 1'b0));
    for (i = 0; i < 11; i++) send_cmd(mk_word(CMD_ALLOC, 6'(i), 1'b1));
    drain_results();
    send_cmd(mk_word(CMD_FREE_CHAIN, 6'd0, 1'b0));
    send_cmd(mk_word(CMD_READ_LINK, 6'd11, 1'b0));
  endtask

  // main sequence
  initial begin
    int i;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BLOCKS_IN_USE;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    rx_hold   = 0;
    fail_cnt  = 0;
    blocks_in_use_m = 7'd40;
    block_bytes_m   = 8'd1;
    for (i = 0; i < MAX_BLOCKS; i++) begin
      fat_kind[i] = KIND_FREE;
      fat_next[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cmds();
    test_register_extremes();
    test_random_chains();
    test_backpressure();

    idle_on = 1'b0;
    drain_results();
    repeat (2 * MAX_BLOCKS + 10) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver stall: random runs, or a counted hold-off when asked
  initial begin
    int   run;
    logic st;
    out_stall = 1'b0;
    run       = 0;
    st        = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
        run = 0;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else begin
        st  = ($urandom_range(0, 2) == 0);
        run = st ? gap_len() - 1 : $urandom_range(0, 7);
        out_stall <= st;
      end
    end
  end

  // compare each returned word with the oldest prediction
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: word with nothing pending: sts=%0d blk=%0d addr=%0d kind=%0d",
                   $time, out_data.status, out_data.result_block, out_data.byte_address,
                   out_data.entry_kind);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.result_block !== want.result_block ||
            out_data.byte_address !== want.byte_address ||
            out_data.entry_kind !== want.entry_kind ||
            out_data.link_target !== want.link_target ||
            out_data.freed_count !== want.freed_count) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: mismatch want sts=%0d blk=%0d addr=%0d kind=%0d next=%0d freed=%0d",
                     $time, want.status, want.result_block, want.byte_address,
                     want.entry_kind, want.link_target, want.freed_count);
            $display("%0t:          got  sts=%0d blk=%0d addr=%0d kind=%0d next=%0d freed=%0d",
                     $time, out_data.status, out_data.result_block, out_data.byte_address,
                     out_data.entry_kind, out_data.link_target, out_data.freed_count);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
